FILE: rtl/cpd_pkg.sv
`default_nettype none
package cpd_pkg;

  localparam int MAX_PAYLOAD_DEF = 45;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECEIVE_ENABLE = 2'd3;

  localparam logic [7:0]  START_BYTE_RST     = 8'hAA;
  localparam logic [5:0]  PAYLOAD_LIMIT_RST  = 6'h2D;
  localparam logic [15:0] IDLE_TIMEOUT_RST   = 16'd5000;
  localparam logic        RECEIVE_ENABLE_RST = 1'b1;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [1:0] VERDICT_GOOD     = 2'd0;
  localparam logic [1:0] VERDICT_CRC      = 2'd1;
  localparam logic [1:0] VERDICT_OVERFLOW = 2'd2;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  // reflected crc-8, one byte, lsb first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc_in;
    d = data;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[0];
      c  = c >> 1;
      d  = d >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cpd_in_if.sv
`default_nettype none
interface cpd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/cpd_out_if.sv
`default_nettype none
interface cpd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] verdict;
  logic [7:0] command;
  logic [7:0] status_byte;
  logic [7:0] payload_length;
  logic [7:0] payload_byte;
  logic [5:0] payload_index;
  logic       last;

  modport source (output valid, output kind, output verdict, output command,
                  output status_byte, output payload_length, output payload_byte,
                  output payload_index, output last, input ready);
  modport sink (input valid, input kind, input verdict, input command,
                input status_byte, input payload_length, input payload_byte,
                input payload_index, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/cpd_cfg_if.sv
`default_nettype none
interface cpd_cfg_if;
  import cpd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/crc8_packet_deframer_core.sv
// crc8_packet_deframer_core
// in_if: one transaction per received byte (req_type 0) or timer tick (req_type 1).
//   frame layout: start byte, command, status, length, payload, crc-8 check byte.
// out_if: result transactions; after a good frame the stored payload bytes
//   (kind 0) and then one verdict (kind 1, last 1); otherwise only the verdict.
// cfg_if: register writes, always ready; index 0 start byte, 1 payload limit,
//   2 idle timeout, 3 receive enable. write only while the block is idle.
// flow: a byte or tick that produces no result leaves in_if.ready high. a
//   byte that ends a frame holds in_if.ready low until its results are
//   loaded: for each payload byte a read of the payload memory (ST_READ),
//   then a load of the output register (ST_EMIT), and last the verdict
//   (ST_VERD); a stalled receiver holds off each load.
// output: a lone verdict passes through ST_VERD into the output register;
//   after a good frame with payload the first byte passes ST_READ and ST_EMIT.
// payload bytes sit in a synchronous memory with one write and one read port,
//   read through a registered output.
// reset: configuration returns to defaults, the frame and idle counter clear;
//   payload memory contents are not cleared and need no clearing pass.
// a stalled receiver holds the output register and the drain waits on it.
`default_nettype none
module crc8_packet_deframer_core #(
  parameter int MAX_PAYLOAD = cpd_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cpd_in_if.sink    in_if,
  cpd_out_if.source out_if,
  cpd_cfg_if.sink   cfg_if
);
  import cpd_pkg::*;

  localparam int LIM_MAX = (MAX_PAYLOAD < 63) ? MAX_PAYLOAD : 63;
  localparam int POS_W   = $clog2(LIM_MAX + 5);
  localparam int ADDR_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_VERD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  start_byte_r;
  logic [5:0]  payload_limit_r;
  logic [15:0] idle_timeout_r;
  logic        receive_enable_r;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [7:0]        crc_r, crc_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [7:0]        sts_r, sts_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [15:0]       idle_r, idle_nxt;
  logic [1:0]        verdict_r, verdict_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;

  logic [7:0] mem [MAX_PAYLOAD];
  logic [7:0] rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;

  logic       out_valid_r, out_valid_nxt;
  logic       out_kind_r, out_kind_nxt;
  logic [1:0] out_verdict_r, out_verdict_nxt;
  logic [7:0] out_cmd_r, out_cmd_nxt;
  logic [7:0] out_sts_r, out_sts_nxt;
  logic [7:0] out_len_r, out_len_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic [5:0] out_idx_r, out_idx_nxt;
  logic       out_last_r, out_last_nxt;

  logic        in_acc;
  logic        out_free;
  logic        clr;
  logic [7:0]  lim_eff;
  logic [8:0]  pay_end;
  logic [15:0] ticks_inc;
  logic [7:0]  rd_idx8;
  logic [7:0]  b;

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_free     = !out_valid_r || out_if.ready;
  assign b            = in_if.rx_byte;
  assign lim_eff      = ({2'b00, payload_limit_r} > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD)
                                                                      : {2'b00, payload_limit_r};
  assign pay_end      = {1'b0, len_r} + 9'd4;
  assign ticks_inc    = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign rd_idx8      = 8'(rd_idx_r);
  assign mem_wa       = ADDR_W'(pos_r - POS_W'(4));

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    crc_nxt         = crc_r;
    cmd_nxt         = cmd_r;
    sts_nxt         = sts_r;
    len_nxt         = len_r;
    idle_nxt        = idle_r;
    verdict_nxt     = verdict_r;
    rd_idx_nxt      = rd_idx_r;
    mem_we          = 1'b0;
    clr             = 1'b0;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_kind_nxt    = out_kind_r;
    out_verdict_nxt = out_verdict_r;
    out_cmd_nxt     = out_cmd_r;
    out_sts_nxt     = out_sts_r;
    out_len_nxt     = out_len_r;
    out_byte_nxt    = out_byte_r;
    out_idx_nxt     = out_idx_r;
    out_last_nxt    = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_if.req_type == REQ_TICK) begin
            if (pos_r == '0) begin
              idle_nxt = '0;
            end else if (ticks_inc >= idle_timeout_r) begin
              clr = 1'b1;
            end else begin
              idle_nxt = ticks_inc;
            end
          end else begin
            idle_nxt = '0;
            if (!receive_enable_r) begin
              clr = 1'b1;
            end else if (pos_r == POS_W'(0)) begin
              if (b == start_byte_r) begin
                crc_nxt = crc8_feed(crc_r, b);
                pos_nxt = POS_W'(1);
              end
            end else if (pos_r == POS_W'(1)) begin
              cmd_nxt = b;
              crc_nxt = crc8_feed(crc_r, b);
              pos_nxt = POS_W'(2);
            end else if (pos_r == POS_W'(2)) begin
              sts_nxt = b;
              crc_nxt = crc8_feed(crc_r, b);
              pos_nxt = POS_W'(3);
            end else if (pos_r == POS_W'(3)) begin
              len_nxt = b;
              if (b > lim_eff) begin
                verdict_nxt = VERDICT_OVERFLOW;
                state_nxt   = ST_VERD;
              end else begin
                crc_nxt = crc8_feed(crc_r, b);
                pos_nxt = POS_W'(4);
              end
            end else if (9'(pos_r) < pay_end) begin
              mem_we  = 1'b1;
              crc_nxt = crc8_feed(crc_r, b);
              pos_nxt = pos_r + POS_W'(1);
            end else if (crc_r == b) begin
              verdict_nxt = VERDICT_GOOD;
              rd_idx_nxt  = '0;
              state_nxt   = (len_r == 8'd0) ? ST_VERD : ST_READ;
            end else begin
              verdict_nxt = VERDICT_CRC;
              state_nxt   = ST_VERD;
            end
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_PAYLOAD;
          out_verdict_nxt = VERDICT_GOOD;
          out_cmd_nxt     = cmd_r;
          out_sts_nxt     = sts_r;
          out_len_nxt     = len_r;
          out_byte_nxt    = rd_data_r;
          out_idx_nxt     = rd_idx8[5:0];
          out_last_nxt    = 1'b0;
          if (rd_idx8 + 8'd1 == len_r) begin
            state_nxt = ST_VERD;
          end else begin
            rd_idx_nxt = rd_idx_r + ADDR_W'(1);
            state_nxt  = ST_READ;
          end
        end
      end
      ST_VERD: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_VERDICT;
          out_verdict_nxt = verdict_r;
          out_cmd_nxt     = cmd_r;
          out_sts_nxt     = sts_r;
          out_len_nxt     = len_r;
          out_byte_nxt    = 8'd0;
          out_idx_nxt     = 6'd0;
          out_last_nxt    = 1'b1;
          clr             = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (clr) begin
      pos_nxt  = '0;
      crc_nxt  = '0;
      cmd_nxt  = '0;
      sts_nxt  = '0;
      len_nxt  = '0;
      idle_nxt = '0;
    end
  end

  // payload memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= b;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      pos_r            <= '0;
      crc_r            <= '0;
      cmd_r            <= '0;
      sts_r            <= '0;
      len_r            <= '0;
      idle_r           <= '0;
      out_valid_r      <= 1'b0;
      start_byte_r     <= START_BYTE_RST;
      payload_limit_r  <= PAYLOAD_LIMIT_RST;
      idle_timeout_r   <= IDLE_TIMEOUT_RST;
      receive_enable_r <= RECEIVE_ENABLE_RST;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      cmd_r       <= cmd_nxt;
      sts_r       <= sts_nxt;
      len_r       <= len_nxt;
      idle_r      <= idle_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_START_BYTE:     start_byte_r     <= cfg_if.data[7:0];
          CFG_PAYLOAD_LIMIT:  payload_limit_r  <= cfg_if.data[5:0];
          CFG_IDLE_TIMEOUT:   idle_timeout_r   <= cfg_if.data[15:0];
          CFG_RECEIVE_ENABLE: receive_enable_r <= cfg_if.data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    verdict_r     <= verdict_nxt;
    rd_idx_r      <= rd_idx_nxt;
    out_kind_r    <= out_kind_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_cmd_r     <= out_cmd_nxt;
    out_sts_r     <= out_sts_nxt;
    out_len_r     <= out_len_nxt;
    out_byte_r    <= out_byte_nxt;
    out_idx_r     <= out_idx_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.kind           = out_kind_r;
  assign out_if.verdict        = out_verdict_r;
  assign out_if.command        = out_cmd_r;
  assign out_if.status_byte    = out_sts_r;
  assign out_if.payload_length = out_len_r;
  assign out_if.payload_byte   = out_byte_r;
  assign out_if.payload_index  = out_idx_r;
  assign out_if.last           = out_last_r;

endmodule
`default_nettype wire

FILE: tb/cpd_tb_pkg.sv
package cpd_tb_pkg;
  import cpd_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [1:0] verdict;
    logic [7:0] command;
    logic [7:0] status_byte;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
    logic [5:0] payload_index;
    logic       last;
  } frame_result_t;

  class deframer_scoreboard;
    logic [7:0]    start_value;
    logic [5:0]    length_cap;
    logic [15:0]   timeout_ticks;
    logic          rx_on;
    int            position;
    logic [7:0]    crc;
    logic [7:0]    cmd;
    logic [7:0]    stat;
    logic [7:0]    len;
    logic [7:0]    store [MAX_PAYLOAD_DEF];
    logic [15:0]   ticks;
    frame_result_t expected_q [$];
    int unsigned   mismatches;

    function new();
      start_value   = START_BYTE_RST;
      length_cap    = PAYLOAD_LIMIT_RST;
      timeout_ticks = IDLE_TIMEOUT_RST;
      rx_on         = RECEIVE_ENABLE_RST;
      mismatches    = 0;
      foreach (store[i]) store[i] = 8'h00;
      clear_frame();
    endfunction

    function void clear_frame();
      position = 0;
      crc      = 8'h00;
      cmd      = 8'h00;
      stat     = 8'h00;
      len      = 8'h00;
      ticks    = 16'h0000;
    endfunction

    // reflected crc-8, data taken lsb first
    function logic [7:0] crc_step(logic [7:0] c, logic [7:0] d);
      for (int i = 0; i < 8; i++) begin
        if (c[0] ^ d[i]) begin
          c = (c >> 1) ^ CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
      return c;
    endfunction

    function int payload_cap();
      return (length_cap > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(length_cap);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_START_BYTE:     start_value   = data[7:0];
        CFG_PAYLOAD_LIMIT:  length_cap    = data[5:0];
        CFG_IDLE_TIMEOUT:   timeout_ticks = data;
        CFG_RECEIVE_ENABLE: rx_on         = data[0];
        default: ;
      endcase
    endfunction

    function void push_result(logic kind, logic [1:0] verdict, logic [7:0] pbyte,
                              logic [5:0] pindex, logic last);
      frame_result_t r;
      r.kind           = kind;
      r.verdict        = verdict;
      r.command        = cmd;
      r.status_byte    = stat;
      r.payload_length = len;
      r.payload_byte   = pbyte;
      r.payload_index  = pindex;
      r.last           = last;
      expected_q.push_back(r);
    endfunction

    function void note_input(logic req, logic [7:0] b);
      if (req == REQ_TICK) begin
        if (position == 0) begin
          ticks = 16'h0000;
        end else begin
          if (ticks != 16'hFFFF) ticks++;
          if (ticks >= timeout_ticks) clear_frame();
        end
        return;
      end
      ticks = 16'h0000;
      if (!rx_on) begin
        clear_frame();
        return;
      end
      if (position == 0) begin
        if (b == start_value) begin
          crc      = crc_step(crc, b);
          position = 1;
        end
      end else if (position == 1) begin
        cmd      = b;
        crc      = crc_step(crc, b);
        position = 2;
      end else if (position == 2) begin
        stat     = b;
        crc      = crc_step(crc, b);
        position = 3;
      end else if (position == 3) begin
        len = b;
        if (int'(b) > payload_cap()) begin
          push_result(KIND_VERDICT, VERDICT_OVERFLOW, 8'h00, 6'd0, 1'b1);
          clear_frame();
        end else begin
          crc      = crc_step(crc, b);
          position = 4;
        end
      end else if (position < 4 + int'(len)) begin
        store[position-4] = b;
        crc               = crc_step(crc, b);
        position++;
      end else begin
        if (crc == b) begin
          for (int i = 0; i < int'(len); i++) begin
            push_result(KIND_PAYLOAD, VERDICT_GOOD, store[i], 6'(i), 1'b0);
          end
          push_result(KIND_VERDICT, VERDICT_GOOD, 8'h00, 6'd0, 1'b1);
        end else begin
          push_result(KIND_VERDICT, VERDICT_CRC, 8'h00, 6'd0, 1'b1);
        end
        clear_frame();
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d verdict %0d", got.kind, got.verdict));
        return;
      end
      want = expected_q.pop_front();
      check_field("kind", got.kind, want.kind);
      check_field("verdict", got.verdict, want.verdict);
      check_field("command", got.command, want.command);
      check_field("status_byte", got.status_byte, want.status_byte);
      check_field("payload_length", got.payload_length, want.payload_length);
      check_field("payload_byte", got.payload_byte, want.payload_byte);
      check_field("payload_index", got.payload_index, want.payload_index);
      check_field("last", got.last, want.last);
    endtask

    task report_leftover();
      if (expected_q.size() != 0) begin
        report($sformatf("%0d results never arrived", expected_q.size()));
      end
    endtask
  endclass

endpackage

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cpd_pkg::*;
  import cpd_tb_pkg::*;

  typedef enum int {SHAPE_GOOD, SHAPE_BAD_CRC, SHAPE_OVERFLOW, SHAPE_CUT} frame_shape_t;

  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int DRAIN_GUARD  = 5000;

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct = 35;
  int   hold_requests = 0;
  int   frame_items = 0;
  int   cycle_count = 0;

  deframer_scoreboard sb;

  cpd_in_if  in_bus ();
  cpd_out_if out_bus ();
  cpd_cfg_if cfg_bus ();

  crc8_packet_deframer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned   stall_left;
    int            holds_taken;
    frame_result_t got;
    stall_left    = 0;
    holds_taken   = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        got.kind           = out_bus.kind;
        got.verdict        = out_bus.verdict;
        got.command        = out_bus.command;
        got.status_byte    = out_bus.status_byte;
        got.payload_length = out_bus.payload_length;
        got.payload_byte   = out_bus.payload_byte;
        got.payload_index  = out_bus.payload_index;
        got.last           = out_bus.last;
        sb.check_result(got);
      end
      if (hold_requests != holds_taken) begin
        holds_taken = hold_requests;
        stall_left  = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99, 0) >= idle_pct);
      end
    end
  end

  task automatic send_item(input logic req, input logic [7:0] b);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.req_type <= req;
    in_bus.rx_byte  <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_input(req, b);
  endtask

  task automatic send_framed(input logic [7:0] body [$], input logic [7:0] crc_flip);
    logic [7:0] crc;
    crc = 8'h00;
    foreach (body[i]) begin
      crc = sb.crc_step(crc, body[i]);
      send_item(REQ_BYTE, body[i]);
    end
    send_item(REQ_BYTE, crc ^ crc_flip);
  endtask

  task automatic send_frame(input frame_shape_t shape, input int force_len, input int pause);
    logic [7:0] seq [$];
    logic [7:0] crc;
    int         cap;
    int         len;
    int         cut;
    cap = sb.payload_cap();
    if (shape == SHAPE_OVERFLOW) begin
      len = $urandom_range(255, cap + 1);
    end else if (force_len >= 0) begin
      len = force_len;
    end else begin
      case ($urandom_range(9, 0))
        0: len = cap;
        1: len = $urandom_range(cap, 0);
        default: len = $urandom_range((cap < 6) ? cap : 6, 0);
      endcase
    end
    seq.push_back(sb.start_value);
    seq.push_back(8'($urandom));
    seq.push_back(8'($urandom));
    seq.push_back(8'(len));
    if (shape != SHAPE_OVERFLOW) begin
      repeat (len) seq.push_back(8'($urandom));
      crc = 8'h00;
      foreach (seq[i]) crc = sb.crc_step(crc, seq[i]);
      if (shape == SHAPE_BAD_CRC) crc ^= 8'($urandom_range(255, 1));
      seq.push_back(crc);
    end
    cut = (shape == SHAPE_CUT) ? $urandom_range(seq.size() - 1, 1) : seq.size();
    for (int i = 0; i < cut; i++) begin
      if (i == 2) begin
        repeat (pause) send_item(REQ_TICK, 8'($urandom));
      end else if (i > 0 && $urandom_range(99, 0) < 4) begin
        repeat ($urandom_range(2, 1)) send_item(REQ_TICK, 8'($urandom));
      end
      send_item(REQ_BYTE, seq[i]);
    end
    frame_items += cut;
  endtask

  task automatic random_traffic(input int count);
    int first;
    int pick;
    int tick_span;
    first = frame_items;
    while (frame_items - first < count) begin
      pick      = $urandom_range(99, 0);
      tick_span = (sb.timeout_ticks <= 16'd8) ? int'(sb.timeout_ticks) + 2 : 4;
      if (pick < 50) begin
        send_frame(SHAPE_GOOD, -1, 0);
      end else if (pick < 60) begin
        send_frame(SHAPE_BAD_CRC, -1, 0);
      end else if (pick < 67) begin
        send_frame(SHAPE_OVERFLOW, -1, 0);
      end else if (pick < 75) begin
        send_frame(SHAPE_CUT, -1, 0);
      end else if (pick < 88) begin
        send_item(REQ_BYTE, 8'($urandom));
      end else begin
        repeat ($urandom_range(tick_span, 1)) send_item(REQ_TICK, 8'($urandom));
      end
    end
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    sb.write_reg(idx, value);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] start, input logic [5:0] cap,
                           input logic [15:0] timeout, input logic enable);
    settle();
    write_reg(CFG_START_BYTE, {8'h00, start});
    write_reg(CFG_PAYLOAD_LIMIT, {10'h000, cap});
    write_reg(CFG_IDLE_TIMEOUT, timeout);
    write_reg(CFG_RECEIVE_ENABLE, {15'h0000, enable});
  endtask

  initial begin : stimulus
    sb              = new();
    rst_n           = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.req_type = REQ_BYTE;
    in_bus.rx_byte  = 8'h00;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = CFG_START_BYTE;
    cfg_bus.data    = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed cases under reset configuration
    send_item(REQ_TICK, 8'hFF);
    send_item(REQ_BYTE, 8'h55);
    send_framed('{8'hAA, 8'h00, 8'hFF, 8'h00}, 8'h00);
    send_framed('{8'hAA, 8'hFF, 8'h00, 8'h02, 8'h00, 8'hFF}, 8'h00);
    send_framed('{8'hAA, 8'h12, 8'h34, 8'h01, 8'h56}, 8'h01);
    send_item(REQ_BYTE, 8'hAA);
    send_item(REQ_BYTE, 8'h01);
    send_item(REQ_BYTE, 8'h02);
    send_item(REQ_BYTE, 8'hFF);

    // limit above the buffer size, short timeout
    configure(8'h00, 6'd63, 16'd3, 1'b1);
    send_frame(SHAPE_GOOD, MAX_PAYLOAD_DEF, 0);
    random_traffic(25);

    // zero limit, zero timeout
    configure(8'hFF, 6'd0, 16'd0, 1'b1);
    random_traffic(15);

    // receiver disabled
    configure(8'hAA, 6'd45, 16'd5000, 1'b0);
    random_traffic(10);

    // longest timeout, no idling on either side
    idle_pct <= 0;
    configure(8'h3C, 6'd12, 16'd65535, 1'b1);
    send_frame(SHAPE_GOOD, 2, 3);
    send_frame(SHAPE_GOOD, 2, 5);
    random_traffic(15);

    // receiver holds off while long frames keep coming
    idle_pct <= 35;
    configure(8'hAA, 6'd45, 16'd5000, 1'b1);
    hold_requests <= hold_requests + 1;
    repeat (2) send_frame(SHAPE_GOOD, 20, 0);
    random_traffic(25);

    settle();
    sb.report_leftover();
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cpd_pkg.sv
rtl/cpd_in_if.sv
rtl/cpd_out_if.sv
rtl/cpd_cfg_if.sv
rtl/crc8_packet_deframer_core.sv
tb/cpd_tb_pkg.sv
tb/testbench.sv
